// ----- rtl/core/pssu_pkg.sv -----
// ----------------------------------------------------------------------------
// pssu_pkg
// Shared types and constants of the polytope support point search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pssu_pkg;

   localparam int NUM_POLY = 4;
   localparam int NUM_VERT = 64;
   localparam int NUM_NBR  = 8;
   localparam int COORD_W  = 32;

   localparam int POLY_W  = $clog2(NUM_POLY);
   localparam int VERT_W  = $clog2(NUM_VERT);
   localparam int SLOT_W  = $clog2(NUM_NBR);
   localparam int NBR_W   = VERT_W + 1;
   localparam int VADDR_W = POLY_W + VERT_W;
   localparam int NADDR_W = POLY_W + VERT_W + SLOT_W;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int DOT_W   = PROD_W + 2;

   localparam logic [NBR_W-1:0]  NBR_EMPTY = NBR_W'(NUM_VERT);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_NBR - 1);

   // request mode codes
   localparam logic [1:0] MODE_WVERT = 2'd0;
   localparam logic [1:0] MODE_WNBR  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SEARCH_MODE = 3'd0;
   localparam logic [2:0] REG_POLY_COUNT  = 3'd1;
   localparam logic [2:0] REG_VCOUNT_A    = 3'd2;
   localparam logic [2:0] REG_VCOUNT_B    = 3'd3;
   localparam logic [2:0] REG_VCOUNT_C    = 3'd4;
   localparam logic [2:0] REG_VCOUNT_D    = 3'd5;

   typedef enum logic [1:0] {
      OP_WVERT,
      OP_WNBR,
      OP_QUERY,
      OP_QZERO
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [POLY_W-1:0]          poly;
      logic [VERT_W-1:0]          vert;
      logic [SLOT_W-1:0]          slot;
      logic [NBR_W-1:0]           nbr;
      logic signed [COORD_W-1:0]  vx;
      logic signed [COORD_W-1:0]  vy;
      logic signed [COORD_W-1:0]  vz;
   } item_type;

   typedef struct packed {
      logic                             search_mode;
      logic [POLY_W-1:0]                poly_last;
      logic [NUM_POLY-1:0][VERT_W-1:0]  vert_last;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/pssu_ram.sv -----
// ----------------------------------------------------------------------------
// pssu_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pssu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pssu_front.sv -----
// ----------------------------------------------------------------------------
// pssu_front
// Accepts request transactions, classifies them and queues them for the
// back end in a two entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pssu_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [1:0]                          req_poly_sel,
   input  wire logic [5:0]                          req_vert_sel,
   input  wire logic [2:0]                          req_slot_sel,
   input  wire logic [6:0]                          req_neighbor_value,
   input  wire logic signed [31:0]                  req_coord_x,
   input  wire logic signed [31:0]                  req_coord_y,
   input  wire logic signed [31:0]                  req_coord_z,
   input  wire logic signed [31:0]                  req_dir_x,
   input  wire logic signed [31:0]                  req_dir_y,
   input  wire logic signed [31:0]                  req_dir_z,
   input  wire logic                                clearing,
   output logic                                     q_valid,
   output pssu_pkg::item_type                       q_item,
   input  wire logic                                q_pop
);

   pssu_pkg::item_type buf_ff [2];
   logic [1:0]         count_ff;
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic               push;
   pssu_pkg::item_type item;

   assign busy = clearing || (count_ff == 2'd2);

   always_comb begin
      item.poly = req_poly_sel;
      item.vert = req_vert_sel;
      item.slot = req_slot_sel;
      item.nbr  = req_neighbor_value;
      item.vx   = req_coord_x;
      item.vy   = req_coord_y;
      item.vz   = req_coord_z;
      item.op   = pssu_pkg::OP_WVERT;
      push      = start && !busy;
      case (req_mode)
         pssu_pkg::MODE_WVERT: begin
            item.op = pssu_pkg::OP_WVERT;
         end
         pssu_pkg::MODE_WNBR: begin
            item.op = pssu_pkg::OP_WNBR;
         end
         pssu_pkg::MODE_QUERY: begin
            item.vx = req_dir_x;
            item.vy = req_dir_y;
            item.vz = req_dir_z;
            if (req_dir_x == '0 && req_dir_y == '0 && req_dir_z == '0) begin
               item.op = pssu_pkg::OP_QZERO;
            end else begin
               item.op = pssu_pkg::OP_QUERY;
            end
         end
         default: begin
            // unused mode: drop
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            buf_ff[wr_ptr_ff] <= item;
            wr_ptr_ff         <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = buf_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- rtl/core/pssu_dot.sv -----
// ----------------------------------------------------------------------------
// pssu_dot
// Exact dot product pipeline: vertex read, three products, wide sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pssu_dot (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   issue,
   input  wire logic [pssu_pkg::VADDR_W-1:0]           issue_tag,
   input  wire logic [3*pssu_pkg::COORD_W-1:0]         vtx,
   input  wire logic signed [pssu_pkg::COORD_W-1:0]    dir_x,
   input  wire logic signed [pssu_pkg::COORD_W-1:0]    dir_y,
   input  wire logic signed [pssu_pkg::COORD_W-1:0]    dir_z,
   output logic                                        out_valid,
   output logic [pssu_pkg::VADDR_W-1:0]                out_tag,
   output logic signed [pssu_pkg::DOT_W-1:0]           out_dot,
   output logic                                        busy
);

   localparam int CW = pssu_pkg::COORD_W;
   localparam int PW = pssu_pkg::PROD_W;

   logic                               v0_ff, v1_ff, v2_ff;
   logic [pssu_pkg::VADDR_W-1:0]       t0_ff, t1_ff, t2_ff;
   logic signed [PW-1:0]               px_ff, py_ff, pz_ff;
   logic signed [pssu_pkg::DOT_W-1:0]  dot_ff;
   logic signed [CW-1:0]               vx, vy, vz;

   assign vx = $signed(vtx[3*CW-1:2*CW]);
   assign vy = $signed(vtx[2*CW-1:CW]);
   assign vz = $signed(vtx[CW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      t0_ff  <= issue_tag;
      t1_ff  <= t0_ff;
      t2_ff  <= t1_ff;
      px_ff  <= vx * dir_x;
      py_ff  <= vy * dir_y;
      pz_ff  <= vz * dir_z;
      dot_ff <= {{2{px_ff[PW-1]}}, px_ff} + {{2{py_ff[PW-1]}}, py_ff}
              + {{2{pz_ff[PW-1]}}, pz_ff};
   end

   assign out_valid = v2_ff;
   assign out_tag   = t2_ff;
   assign out_dot   = dot_ff;
   assign busy      = v0_ff || v1_ff || v2_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pssu_back.sv -----
// ----------------------------------------------------------------------------
// pssu_back
// Executes queued transactions: store writes, linear scan, hill climb and zero direction queries.
// ----------------------------------------------------------------------------
`default_nettype none

module pssu_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pssu_pkg::cfg_type     cfg,
   input  wire logic                  q_valid,
   input  wire pssu_pkg::item_type    q_item,
   output logic                       q_pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_best_poly,
   output logic [5:0]                 rsp_best_vertex,
   output logic signed [31:0]         rsp_support_x,
   output logic signed [31:0]         rsp_support_y,
   output logic signed [31:0]         rsp_support_z
);

   localparam int CW  = pssu_pkg::COORD_W;
   localparam int PWD = pssu_pkg::POLY_W;
   localparam int VW  = pssu_pkg::VERT_W;
   localparam int SW  = pssu_pkg::SLOT_W;
   localparam int NW  = pssu_pkg::NBR_W;
   localparam int DW  = pssu_pkg::DOT_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LIN, S_DRAIN, S_CL_START, S_CL_WAITC, S_CL_NRD,
      S_CL_NCHK, S_CL_WAITN, S_CL_DONE, S_FETCH, S_OUT
   } state_type;

   state_type                     state_ff;
   logic [pssu_pkg::NADDR_W-1:0]  clr_ff;
   logic signed [CW-1:0]          dir_x_ff, dir_y_ff, dir_z_ff;
   logic [PWD-1:0]                pj_ff, bp_ff;
   logic [VW-1:0]                 vi_ff, bv_ff, nbr_ff;
   logic [SW-1:0]                 slot_ff;
   logic signed [DW-1:0]          cd_ff, best_ff;
   logic                          have_ff;
   logic [VW-1:0]                 warm_ff [pssu_pkg::NUM_POLY];
   logic                          rsp_valid_ff;
   logic [PWD-1:0]                rsp_poly_ff;
   logic [VW-1:0]                 rsp_vert_ff;
   logic signed [CW-1:0]          rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [VW-1:0]                 vert_last_j;
   logic [VW-1:0]                 cur_start;
   logic [NW-1:0]                 nbr_rd;
   logic                          nbr_ok;
   logic                          issue;
   logic [pssu_pkg::VADDR_W-1:0]  vram_rd_addr;
   logic [3*CW-1:0]               vram_rd_data;
   logic                          vram_we;
   logic                          nram_we;
   logic [pssu_pkg::NADDR_W-1:0]  nram_wr_addr;
   logic [pssu_pkg::NADDR_W-1:0]  nram_rd_addr;
   logic [NW-1:0]                 nram_wr_data;
   logic                          dot_valid;
   logic [pssu_pkg::VADDR_W-1:0]  dot_tag;
   logic signed [DW-1:0]          dot_val;
   logic                          dot_busy;

   always_comb begin
      vert_last_j  = cfg.vert_last[pj_ff];
      cur_start    = (warm_ff[pj_ff] <= vert_last_j) ? warm_ff[pj_ff] : '0;
      nbr_ok       = !nbr_rd[NW-1] && (nbr_rd[VW-1:0] <= vert_last_j);
      issue        = 1'b0;
      q_pop        = 1'b0;
      vram_rd_addr = {bp_ff, bv_ff};
      case (state_ff)
         S_IDLE: begin
            q_pop = q_valid;
         end
         S_LIN: begin
            issue        = 1'b1;
            vram_rd_addr = {pj_ff, vi_ff};
         end
         S_CL_START: begin
            issue        = 1'b1;
            vram_rd_addr = {pj_ff, cur_start};
         end
         S_CL_NCHK: begin
            issue        = nbr_ok;
            vram_rd_addr = {pj_ff, nbr_rd[VW-1:0]};
         end
         default: begin
            vram_rd_addr = {bp_ff, bv_ff};
         end
      endcase
   end

   assign clearing     = (state_ff == S_CLEAR);
   assign vram_we      = q_pop && (q_item.op == pssu_pkg::OP_WVERT);
   assign nram_we      = clearing || (q_pop && (q_item.op == pssu_pkg::OP_WNBR));
   assign nram_wr_addr = clearing ? clr_ff : {q_item.poly, q_item.vert, q_item.slot};
   assign nram_wr_data = clearing ? pssu_pkg::NBR_EMPTY : q_item.nbr;
   assign nram_rd_addr = {pj_ff, vi_ff, slot_ff};

   pssu_ram #(
      .WIDTH (3 * CW),
      .DEPTH (pssu_pkg::NUM_POLY * pssu_pkg::NUM_VERT)
   ) u_vram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr ({q_item.poly, q_item.vert}),
      .wr_data ({q_item.vx, q_item.vy, q_item.vz}),
      .rd_addr (vram_rd_addr),
      .rd_data (vram_rd_data)
   );

   pssu_ram #(
      .WIDTH (NW),
      .DEPTH (pssu_pkg::NUM_POLY * pssu_pkg::NUM_VERT * pssu_pkg::NUM_NBR)
   ) u_nram (
      .clock   (clock),
      .wr_en   (nram_we),
      .wr_addr (nram_wr_addr),
      .wr_data (nram_wr_data),
      .rd_addr (nram_rd_addr),
      .rd_data (nbr_rd)
   );

   pssu_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .issue_tag (vram_rd_addr),
      .vtx       (vram_rd_data),
      .dir_x     (dir_x_ff),
      .dir_y     (dir_y_ff),
      .dir_z     (dir_z_ff),
      .out_valid (dot_valid),
      .out_tag   (dot_tag),
      .out_dot   (dot_val),
      .busy      (dot_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < pssu_pkg::NUM_POLY; p++) begin
            warm_ff[p] <= '0;
         end
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT);

         // linear scan: fold each finished dot product into the running best
         if ((state_ff == S_LIN || state_ff == S_DRAIN) && dot_valid
             && (!have_ff || dot_val > best_ff)) begin
            best_ff                   <= dot_val;
            bp_ff                     <= dot_tag[pssu_pkg::VADDR_W-1:VW];
            bv_ff                     <= dot_tag[VW-1:0];
            have_ff                   <= 1'b1;
            warm_ff[dot_tag[pssu_pkg::VADDR_W-1:VW]] <= dot_tag[VW-1:0];
         end

         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  case (q_item.op)
                     pssu_pkg::OP_QUERY: begin
                        dir_x_ff <= q_item.vx;
                        dir_y_ff <= q_item.vy;
                        dir_z_ff <= q_item.vz;
                        pj_ff    <= '0;
                        vi_ff    <= '0;
                        bp_ff    <= '0;
                        bv_ff    <= '0;
                        have_ff  <= 1'b0;
                        state_ff <= cfg.search_mode ? S_CL_START : S_LIN;
                     end
                     pssu_pkg::OP_QZERO: begin
                        bp_ff    <= '0;
                        bv_ff    <= '0;
                        state_ff <= S_FETCH;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_LIN: begin
               if (vi_ff == vert_last_j) begin
                  vi_ff <= '0;
                  if (pj_ff == cfg.poly_last) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     pj_ff <= pj_ff + 1'b1;
                  end
               end else begin
                  vi_ff <= vi_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (!dot_busy) begin
                  state_ff <= S_FETCH;
               end
            end
            S_CL_START: begin
               vi_ff    <= cur_start;
               state_ff <= S_CL_WAITC;
            end
            S_CL_WAITC: begin
               if (dot_valid) begin
                  cd_ff    <= dot_val;
                  slot_ff  <= '0;
                  state_ff <= S_CL_NRD;
               end
            end
            S_CL_NRD: begin
               state_ff <= S_CL_NCHK;
            end
            S_CL_NCHK: begin
               if (nbr_ok) begin
                  nbr_ff   <= nbr_rd[VW-1:0];
                  state_ff <= S_CL_WAITN;
               end else if (slot_ff == pssu_pkg::SLOT_LAST) begin
                  state_ff <= S_CL_DONE;
               end else begin
                  slot_ff  <= slot_ff + 1'b1;
                  state_ff <= S_CL_NRD;
               end
            end
            S_CL_WAITN: begin
               if (dot_valid) begin
                  if (dot_val > cd_ff) begin
                     // move to the improving neighbor and rescan its slots
                     cd_ff    <= dot_val;
                     vi_ff    <= nbr_ff;
                     slot_ff  <= '0;
                     state_ff <= S_CL_NRD;
                  end else if (slot_ff == pssu_pkg::SLOT_LAST) begin
                     state_ff <= S_CL_DONE;
                  end else begin
                     slot_ff  <= slot_ff + 1'b1;
                     state_ff <= S_CL_NRD;
                  end
               end
            end
            S_CL_DONE: begin
               if (!have_ff || cd_ff > best_ff) begin
                  best_ff        <= cd_ff;
                  bp_ff          <= pj_ff;
                  bv_ff          <= vi_ff;
                  have_ff        <= 1'b1;
                  warm_ff[pj_ff] <= vi_ff;
               end
               if (pj_ff == cfg.poly_last) begin
                  state_ff <= S_FETCH;
               end else begin
                  pj_ff    <= pj_ff + 1'b1;
                  state_ff <= S_CL_START;
               end
            end
            S_FETCH: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_poly_ff  <= bp_ff;
               rsp_vert_ff  <= bv_ff;
               rsp_x_ff     <= $signed(vram_rd_data[3*CW-1:2*CW]);
               rsp_y_ff     <= $signed(vram_rd_data[2*CW-1:CW]);
               rsp_z_ff     <= $signed(vram_rd_data[CW-1:0]);
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_poly   = rsp_poly_ff;
   assign rsp_best_vertex = rsp_vert_ff;
   assign rsp_support_x   = rsp_x_ff;
   assign rsp_support_y   = rsp_y_ff;
   assign rsp_support_z   = rsp_z_ff;

endmodule

`default_nettype wire

// ----- rtl/core/polytope_support_point_search_unit.sv -----
// ----------------------------------------------------------------------------
// polytope_support_point_search_unit
// Support point search over up to four stored convex polytopes.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low. Mode 0
// writes a vertex, mode 1 a neighbor slot, mode 2 queries a direction; mode 3
// is dropped. Requests pass through a two entry queue to the execution
// engine, which does a write as it pops it, and start may be pulsed
// again while earlier transactions are still running.
// Each query returns one response: rsp_valid is high for exactly one cycle
// with the support vertex, its polytope and vertex index. The receiver
// cannot stall the response. Writes return nothing.
// In a query, linear scan issues one dot product per cycle into a three stage
// read, multiply and sum pipeline. Hill climbing works one polytope at a
// time from its start vertex, reading neighbor slots serially and waiting
// for the dot product of each neighbor that is not empty, then a final
// compare. A zero direction skips the search.
// After reset the neighbor store is swept to empty, one slot per cycle over
// all 2048 slots, with busy high. The user must write registers over the APB
// port only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module polytope_support_point_search_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_mode,
   input  wire logic [1:0]          req_poly_sel,
   input  wire logic [5:0]          req_vert_sel,
   input  wire logic [2:0]          req_slot_sel,
   input  wire logic [6:0]          req_neighbor_value,
   input  wire logic signed [31:0]  req_coord_x,
   input  wire logic signed [31:0]  req_coord_y,
   input  wire logic signed [31:0]  req_coord_z,
   input  wire logic signed [31:0]  req_dir_x,
   input  wire logic signed [31:0]  req_dir_y,
   input  wire logic signed [31:0]  req_dir_z,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_best_poly,
   output logic [5:0]               rsp_best_vertex,
   output logic signed [31:0]       rsp_support_x,
   output logic signed [31:0]       rsp_support_y,
   output logic signed [31:0]       rsp_support_z,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic                search_mode_ff;
   logic [2:0]          poly_count_ff;
   logic [6:0]          vcount_ff [4];
   logic                csr_wr;
   logic [2:0]          csr_idx;
   pssu_pkg::cfg_type   cfg;
   logic                clearing;
   logic                q_valid;
   logic                q_pop;
   pssu_pkg::item_type  q_item;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         search_mode_ff <= 1'b0;
         poly_count_ff  <= 3'd1;
         for (int i = 0; i < 4; i++) begin
            vcount_ff[i] <= 7'd1;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            pssu_pkg::REG_SEARCH_MODE: search_mode_ff <= pwdata[0];
            pssu_pkg::REG_POLY_COUNT:  poly_count_ff  <= pwdata[2:0];
            pssu_pkg::REG_VCOUNT_A:    vcount_ff[0]   <= pwdata[6:0];
            pssu_pkg::REG_VCOUNT_B:    vcount_ff[1]   <= pwdata[6:0];
            pssu_pkg::REG_VCOUNT_C:    vcount_ff[2]   <= pwdata[6:0];
            pssu_pkg::REG_VCOUNT_D:    vcount_ff[3]   <= pwdata[6:0];
            default: begin
               search_mode_ff <= search_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pssu_pkg::REG_SEARCH_MODE: prdata = {31'd0, search_mode_ff};
         pssu_pkg::REG_POLY_COUNT:  prdata = {29'd0, poly_count_ff};
         pssu_pkg::REG_VCOUNT_A:    prdata = {25'd0, vcount_ff[0]};
         pssu_pkg::REG_VCOUNT_B:    prdata = {25'd0, vcount_ff[1]};
         pssu_pkg::REG_VCOUNT_C:    prdata = {25'd0, vcount_ff[2]};
         pssu_pkg::REG_VCOUNT_D:    prdata = {25'd0, vcount_ff[3]};
         default:                   prdata = '0;
      endcase
   end

   // clamp counts to the stored range and convert to last index
   always_comb begin
      cfg.search_mode = search_mode_ff;
      if (poly_count_ff == 3'd0) begin
         cfg.poly_last = '0;
      end else if (poly_count_ff > 3'(pssu_pkg::NUM_POLY)) begin
         cfg.poly_last = pssu_pkg::POLY_W'(pssu_pkg::NUM_POLY - 1);
      end else begin
         cfg.poly_last = pssu_pkg::POLY_W'(poly_count_ff - 3'd1);
      end
      for (int p = 0; p < pssu_pkg::NUM_POLY; p++) begin
         if (vcount_ff[p] == 7'd0) begin
            cfg.vert_last[p] = '0;
         end else if (vcount_ff[p] > 7'(pssu_pkg::NUM_VERT)) begin
            cfg.vert_last[p] = pssu_pkg::VERT_W'(pssu_pkg::NUM_VERT - 1);
         end else begin
            cfg.vert_last[p] = pssu_pkg::VERT_W'(vcount_ff[p] - 7'd1);
         end
      end
   end

   pssu_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_poly_sel       (req_poly_sel),
      .req_vert_sel       (req_vert_sel),
      .req_slot_sel       (req_slot_sel),
      .req_neighbor_value (req_neighbor_value),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_dir_x          (req_dir_x),
      .req_dir_y          (req_dir_y),
      .req_dir_z          (req_dir_z),
      .clearing           (clearing),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   pssu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_best_poly   (rsp_best_poly),
      .rsp_best_vertex (rsp_best_vertex),
      .rsp_support_x   (rsp_support_x),
      .rsp_support_y   (rsp_support_y),
      .rsp_support_z   (rsp_support_z)
   );

endmodule

`default_nettype wire
